/* hdl/jtfe_pkg.sv */
// ----------------------------------------------------------------------------
// jtfe_pkg - joint target frame encoder shared definitions
// Widths, frame byte codes and the item record passed from front to back.
// ----------------------------------------------------------------------------
package jtfe_pkg;

   // field widths
   localparam int ANGLE_W = 20;
   localparam int LIMIT_W = 14;
   localparam int PROD_W  = 30;
   localparam int DIGIT_W = 4;
   localparam int BYTE_W  = 8;

   // defaults for the top level parameters
   localparam int NUM_JOINTS_DEF = 6;
   localparam int FRAC_BITS_DEF  = 16;

   // decoupling queue depth
   localparam int QUEUE_DEPTH = 2;

   // limit register
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd3142;
   localparam logic [LIMIT_W-1:0] FIELD_MAX   = 14'd9999;
   localparam logic [9:0]         MRAD_SCALE  = 10'd1000;

   // frame byte codes
   localparam logic [BYTE_W-1:0] BYTE_STX   = 8'h02;
   localparam logic [BYTE_W-1:0] BYTE_ETX   = 8'h03;
   localparam logic [BYTE_W-1:0] BYTE_FS    = 8'h1C;
   localparam logic [BYTE_W-1:0] BYTE_CMD   = 8'h4D;
   localparam logic [BYTE_W-1:0] BYTE_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] BYTE_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h30;

   // one classified and converted joint
   typedef struct packed {
      logic               first;
      logic               last;
      logic               clamp;
      logic               negsign;
      logic [DIGIT_W-1:0] d3;
      logic [DIGIT_W-1:0] d2;
      logic [DIGIT_W-1:0] d1;
      logic [DIGIT_W-1:0] d0;
   } item_type;

endpackage

/* hdl/joint_target_frame_encoder.sv */
// Path: request -> front pipeline -> queue -> result register -> rsp. Throughput:
// one frame byte per cycle while an item waits and rsp_ready is high, set by the byte
// sequencer; a middle joint sends FS, sign and four digits, the first adds STX, length
// and CMD ahead, the last adds ETX and LRC. Reset: synchronous; clears pipeline, queue
// and joint position, zeroes the LRC and loads the joint limit with 3142.
// ----------------------------------------------------------------------------
// joint_target_frame_encoder - ASCII STX/ETX/LRC frame encoder for joint targets
// Converts Q-format radian requests to clamped milliradian fields in a frame.
// ----------------------------------------------------------------------------
module joint_target_frame_encoder #(
   parameter int NUM_JOINTS          = jtfe_pkg::NUM_JOINTS_DEF,
   parameter int ANGLE_FRACTION_BITS = jtfe_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [jtfe_pkg::ANGLE_W-1:0] req_joint_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [jtfe_pkg::BYTE_W-1:0]  rsp_frame_byte,
   output logic                                rsp_run_last,
   output logic                                rsp_frame_end,
   output logic                                rsp_was_clamped,
   input  logic                                csr_wr_en,
   input  logic        [jtfe_pkg::LIMIT_W-1:0] csr_wr_data
);

   logic               front_valid;
   logic               front_ready;
   jtfe_pkg::item_type front_item;
   logic               head_valid;
   logic               head_pop;
   jtfe_pkg::item_type head_item;

   // intake and conversion
   jtfe_front #(
      .NUM_JOINTS (NUM_JOINTS),
      .FRAC_BITS  (ANGLE_FRACTION_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_joint_angle (req_joint_angle),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .out_valid       (front_valid),
      .out_ready       (front_ready),
      .out_item        (front_item)
   );

   // decoupling queue
   jtfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .head_valid (head_valid),
      .pop        (head_pop),
      .head_item  (head_item)
   );

   // byte sequencer
   jtfe_back #(
      .NUM_JOINTS (NUM_JOINTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (head_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_was_clamped (rsp_was_clamped)
   );

endmodule

/* hdl/jtfe_front.sv */
// ----------------------------------------------------------------------------
// jtfe_front - request intake, scaling, clamp and decimal split
// Four-stage pipeline: scale to milliradians, clamp, thousands digit, rest.
// ----------------------------------------------------------------------------
module jtfe_front #(
   parameter int NUM_JOINTS = jtfe_pkg::NUM_JOINTS_DEF,
   parameter int FRAC_BITS  = jtfe_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [jtfe_pkg::ANGLE_W-1:0] req_joint_angle,
   input  logic                                csr_wr_en,
   input  logic        [jtfe_pkg::LIMIT_W-1:0] csr_wr_data,
   output logic                                out_valid,
   input  logic                                out_ready,
   output jtfe_pkg::item_type                  out_item
);

   localparam int PosW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam logic [jtfe_pkg::PROD_W-1:0] Half =
      jtfe_pkg::PROD_W'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic                          first;
      logic                          last;
      logic                          neg;
      logic [jtfe_pkg::PROD_W-1:0]   prod;
   } s1_type;

   typedef struct packed {
      logic                          first;
      logic                          last;
      logic                          clamp;
      logic                          negsign;
      logic [jtfe_pkg::LIMIT_W-1:0]  field;
   } s2_type;

   typedef struct packed {
      logic                          first;
      logic                          last;
      logic                          clamp;
      logic                          negsign;
      logic [jtfe_pkg::DIGIT_W-1:0]  d3;
      logic [9:0]                    rem;
   } s3_type;

   logic [jtfe_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [PosW-1:0]              pos_ff, pos_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s2_valid_ff, s2_valid_in;
   logic                         s3_valid_ff, s3_valid_in;
   logic                         s4_valid_ff, s4_valid_in;
   s1_type                       s1_ff, s1_in;
   s2_type                       s2_ff, s2_in;
   s3_type                       s3_ff, s3_in;
   jtfe_pkg::item_type           s4_ff, s4_in;
   logic                         advance;
   logic                         take;

   // limit register
   always_comb begin
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
   end

   // pipeline moves whenever the last stage can drain
   always_comb begin
      advance   = !s4_valid_ff || out_ready;
      req_ready = advance;
      take      = req_valid && advance;
      out_valid = s4_valid_ff;
      out_item  = s4_ff;
   end

   // joint position, first/last classification and stage 1:
   // magnitude times 1000 with half-up rounding term
   always_comb begin
      logic first_j;
      logic last_j;
      logic [jtfe_pkg::ANGLE_W-1:0] mag;
      first_j = (pos_ff == '0);
      last_j  = (pos_ff == PosW'(NUM_JOINTS - 1));
      pos_in  = pos_ff;
      if (take) begin
         pos_in = last_j ? '0 : pos_ff + PosW'(1);
      end
      s1_in.first = first_j;
      s1_in.last  = last_j;
      s1_in.neg   = req_joint_angle[jtfe_pkg::ANGLE_W-1];
      mag         = s1_in.neg ? jtfe_pkg::ANGLE_W'(-req_joint_angle)
                              : jtfe_pkg::ANGLE_W'(req_joint_angle);
      s1_in.prod  = jtfe_pkg::PROD_W'(mag) * jtfe_pkg::PROD_W'(jtfe_pkg::MRAD_SCALE)
                    + Half;
   end

   // stage 2: drop fraction, clamp to limit (itself capped at FIELD_MAX)
   always_comb begin
      logic [jtfe_pkg::PROD_W-1:0]  mrad;
      logic [jtfe_pkg::LIMIT_W-1:0] lim;
      lim           = (limit_ff > jtfe_pkg::FIELD_MAX) ? jtfe_pkg::FIELD_MAX : limit_ff;
      mrad          = s1_ff.prod >> FRAC_BITS;
      s2_in.first   = s1_ff.first;
      s2_in.last    = s1_ff.last;
      s2_in.clamp   = (mrad > jtfe_pkg::PROD_W'(lim));
      s2_in.field   = s2_in.clamp ? lim : mrad[jtfe_pkg::LIMIT_W-1:0];
      s2_in.negsign = s1_ff.neg && (s2_in.field != '0);
   end

   // stage 3: thousands digit
   always_comb begin
      logic [jtfe_pkg::DIGIT_W-1:0] d;
      d = '0;
      for (int k = 1; k < 10; k++) begin
         if (s2_ff.field >= jtfe_pkg::LIMIT_W'(k * 1000)) begin
            d = jtfe_pkg::DIGIT_W'(k);
         end
      end
      s3_in.first   = s2_ff.first;
      s3_in.last    = s2_ff.last;
      s3_in.clamp   = s2_ff.clamp;
      s3_in.negsign = s2_ff.negsign;
      s3_in.d3      = d;
      s3_in.rem     = 10'(s2_ff.field - jtfe_pkg::LIMIT_W'(d) * 14'd1000);
   end

   // stage 4: hundreds, tens and ones
   always_comb begin
      logic [jtfe_pkg::DIGIT_W-1:0] dh;
      logic [jtfe_pkg::DIGIT_W-1:0] dt;
      logic [6:0]                   r2;
      dh = '0;
      for (int k = 1; k < 10; k++) begin
         if (s3_ff.rem >= 10'(k * 100)) begin
            dh = jtfe_pkg::DIGIT_W'(k);
         end
      end
      r2 = 7'(s3_ff.rem - 10'(dh) * 10'd100);
      dt = '0;
      for (int k = 1; k < 10; k++) begin
         if (r2 >= 7'(k * 10)) begin
            dt = jtfe_pkg::DIGIT_W'(k);
         end
      end
      s4_in.first   = s3_ff.first;
      s4_in.last    = s3_ff.last;
      s4_in.clamp   = s3_ff.clamp;
      s4_in.negsign = s3_ff.negsign;
      s4_in.d3      = s3_ff.d3;
      s4_in.d2      = dh;
      s4_in.d1      = dt;
      s4_in.d0      = jtfe_pkg::DIGIT_W'(r2 - 7'(dt) * 7'd10);
   end

   // stage valids
   always_comb begin
      s1_valid_in = advance ? take        : s1_valid_ff;
      s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = advance ? s2_valid_ff : s3_valid_ff;
      s4_valid_in = advance ? s3_valid_ff : s4_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= jtfe_pkg::LIMIT_RESET;
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         limit_ff    <= limit_in;
         pos_ff      <= pos_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

endmodule

/* hdl/jtfe_queue.sv */
// ----------------------------------------------------------------------------
// jtfe_queue - short item queue between front and back
// Small circular buffer so the front and the byte sequencer stall apart.
// ----------------------------------------------------------------------------
module jtfe_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  jtfe_pkg::item_type push_item,
   output logic               head_valid,
   input  logic               pop,
   output jtfe_pkg::item_type head_item
);

   localparam int Depth = jtfe_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   jtfe_pkg::item_type mem_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               push;

   // pointer and fill bookkeeping
   always_comb begin
      push_ready = (count_ff != CntW'(Depth));
      head_valid = (count_ff != '0);
      head_item  = mem_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/jtfe_back.sv */
// ----------------------------------------------------------------------------
// jtfe_back - frame byte sequencer
// Walks the byte slots of one item, keeps the LRC and drives the result reg.
// ----------------------------------------------------------------------------
module jtfe_back #(
   parameter int NUM_JOINTS = jtfe_pkg::NUM_JOINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  jtfe_pkg::item_type                 head_item,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [jtfe_pkg::BYTE_W-1:0]        rsp_frame_byte,
   output logic                               rsp_run_last,
   output logic                               rsp_frame_end,
   output logic                               rsp_was_clamped
);

   // byte slots of a frame; later joints start at the separator slot
   localparam logic [3:0] SlotStx  = 4'd0;
   localparam logic [3:0] SlotLen3 = 4'd1;
   localparam logic [3:0] SlotLen2 = 4'd2;
   localparam logic [3:0] SlotLen1 = 4'd3;
   localparam logic [3:0] SlotLen0 = 4'd4;
   localparam logic [3:0] SlotCmd  = 4'd5;
   localparam logic [3:0] SlotFs   = 4'd6;
   localparam logic [3:0] SlotSign = 4'd7;
   localparam logic [3:0] SlotD3   = 4'd8;
   localparam logic [3:0] SlotD2   = 4'd9;
   localparam logic [3:0] SlotD1   = 4'd10;
   localparam logic [3:0] SlotD0   = 4'd11;
   localparam logic [3:0] SlotEtx  = 4'd12;
   localparam logic [3:0] SlotLrc  = 4'd13;

   // length field digits
   localparam int FrameLen = 6 * NUM_JOINTS + 3;
   localparam logic [jtfe_pkg::BYTE_W-1:0] Len3 = 8'(48 + (FrameLen / 1000) % 10);
   localparam logic [jtfe_pkg::BYTE_W-1:0] Len2 = 8'(48 + (FrameLen / 100) % 10);
   localparam logic [jtfe_pkg::BYTE_W-1:0] Len1 = 8'(48 + (FrameLen / 10) % 10);
   localparam logic [jtfe_pkg::BYTE_W-1:0] Len0 = 8'(48 + FrameLen % 10);

   logic                        active_ff, active_in;
   logic [3:0]                  step_ff, step_in;
   logic [jtfe_pkg::BYTE_W-1:0] lrc_ff, lrc_in;
   logic                        valid_ff, valid_in;
   logic [jtfe_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                        run_last_ff, frame_end_ff, clamp_ff;
   logic                        advance;
   logic                        fire;
   logic [3:0]                  cur;
   logic [3:0]                  end_slot;

   // slot selection and handshake
   always_comb begin
      advance  = !valid_ff || rsp_ready;
      fire     = head_valid && advance;
      cur      = active_ff ? step_ff : (head_item.first ? SlotStx : SlotFs);
      end_slot = head_item.last ? SlotLrc : SlotD0;
      pop      = fire && (cur == end_slot);
   end

   // byte for the current slot
   always_comb begin
      case (cur)
         SlotStx:  byte_in = jtfe_pkg::BYTE_STX;
         SlotLen3: byte_in = Len3;
         SlotLen2: byte_in = Len2;
         SlotLen1: byte_in = Len1;
         SlotLen0: byte_in = Len0;
         SlotCmd:  byte_in = jtfe_pkg::BYTE_CMD;
         SlotFs:   byte_in = jtfe_pkg::BYTE_FS;
         SlotSign: byte_in = head_item.negsign ? jtfe_pkg::BYTE_MINUS : jtfe_pkg::BYTE_PLUS;
         SlotD3:   byte_in = jtfe_pkg::BYTE_ZERO + 8'(head_item.d3);
         SlotD2:   byte_in = jtfe_pkg::BYTE_ZERO + 8'(head_item.d2);
         SlotD1:   byte_in = jtfe_pkg::BYTE_ZERO + 8'(head_item.d1);
         SlotD0:   byte_in = jtfe_pkg::BYTE_ZERO + 8'(head_item.d0);
         SlotEtx:  byte_in = jtfe_pkg::BYTE_ETX;
         SlotLrc:  byte_in = lrc_ff;
         default:  byte_in = '0;
      endcase
   end

   // sequencer, lrc and output valid next values
   always_comb begin
      active_in = active_ff;
      step_in   = step_ff;
      lrc_in    = lrc_ff;
      valid_in  = advance ? 1'b0 : valid_ff;
      if (fire) begin
         valid_in  = 1'b1;
         active_in = !pop;
         step_in   = cur + 4'd1;
         if (cur == SlotStx || cur == SlotLrc) begin
            lrc_in = '0;
         end else begin
            lrc_in = lrc_ff ^ byte_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= '0;
         lrc_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
         lrc_ff    <= lrc_in;
         valid_ff  <= valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff      <= byte_in;
         run_last_ff  <= (cur == end_slot);
         frame_end_ff <= (cur == SlotLrc);
         clamp_ff     <= head_item.clamp;
      end
   end

   always_comb begin
      rsp_valid       = valid_ff;
      rsp_frame_byte  = byte_ff;
      rsp_run_last    = run_last_ff;
      rsp_frame_end   = frame_end_ff;
      rsp_was_clamped = clamp_ff;
   end

endmodule
